FILE: src/assert_macros.svh
// Assertion macros used by the top level RTL of the gas ratio to ppm block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GSR_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GSR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSR_ASSERT_CLK(label, prop, msg)
`define GSR_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: src/gsr_pkg.sv
// Types, curve constants and elaboration helpers of the gas ratio to ppm block
package gsr_pkg;

  localparam int MEAS_W        = 24;
  localparam int RES_BITS_DFLT = 24;
  localparam int RATIO_W       = 24;
  localparam int CONC_W        = 24;
  localparam int FRAC_W        = 24;
  localparam int LOG_W         = 29;
  localparam int NUM_W         = 41;
  localparam int ABS_W         = 40;
  localparam int DIVQ_W        = 32;
  localparam int DIVR_W        = 11;
  localparam int Y_W           = 35;
  localparam int ACC_W         = 32;
  localparam int EXP_W         = 5;

  localparam logic [MEAS_W-1:0] AIR_RESET = MEAS_W'(1);
  localparam logic [CONC_W-1:0] CONC_MAX  = '1;
  localparam logic signed [NUM_W-1:0] LOG2_TEN_Q24 = NUM_W'(55732705);
  localparam logic signed [NUM_W-1:0] MILLI        = NUM_W'(1000);

  typedef enum logic [1:0] {
    RES_EXP,
    RES_ZERO,
    RES_MAX
  } res_kind_t;

  typedef struct packed {
    logic [1:0]        gas_kind;
    logic [MEAS_W-1:0] measured_resistance;
  } gsr_in_t;

  typedef struct packed {
    logic [CONC_W-1:0] concentration;
    logic              error;
  } gsr_out_t;

  typedef struct packed {
    res_kind_t  kind;
    logic       err;
    logic [1:0] gas;
  } gsr_tag_t;

  localparam logic [RATIO_W-1:0] THR [4] = '{24'd1310, 24'd26214, 24'd9175, 24'd13107};
  localparam logic [DIVR_W-1:0] A_HI_N [4] = '{11'd699, 11'd509, 11'd632, 11'd778};
  localparam logic [DIVR_W-1:0] A_LO_N [4] = '{11'd834, 11'd1125, 11'd1343, 11'd1602};
  localparam logic signed [11:0] B_HI [4] = '{-12'sd301, -12'sd155, -12'sd854, -12'sd1106};
  localparam logic signed [11:0] B_LO [4] = '{-12'sd31, 12'sd139, -12'sd854, -12'sd1537};

  function automatic logic [63:0] gsr_isqrt(input logic [63:0] n);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] b;
    x   = n;
    res = '0;
    b   = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [ACC_W-1:0] gsr_root(input int n);
    logic [63:0] r;
    r = 64'd2 << 30;
    for (int k = 1; k <= FRAC_W; k++) begin
      if (k <= n) begin
        r = gsr_isqrt(r << 30);
      end
    end
    return r[ACC_W-1:0];
  endfunction

endpackage

FILE: src/gsr_ratio_div.sv
// Pipelined restoring divider forming the Q8.16 resistance ratio
module gsr_ratio_div import gsr_pkg::*; #(
  parameter int RW = RES_BITS_DFLT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  gsr_tag_t           in_tag,
  input  logic [RW-1:0]      meas,
  input  logic [RW-1:0]      air,
  output logic               out_v,
  output gsr_tag_t           out_tag,
  output logic [RATIO_W-1:0] out_ratio
);

  localparam int NS = RATIO_W;

  logic               v_r   [0:NS];
  gsr_tag_t           tag_r [0:NS];
  logic               sat_r [0:NS];
  logic [RW-1:0]      rem_r [0:NS];
  logic [RATIO_W-1:0] q_r   [0:NS];
  logic [7:0]         lo_r  [0:NS];

  logic zero;
  logic sat;

  assign zero = (meas == '0) || (air == '0);
  assign sat  = {8'b0, meas} >= {air, 8'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= '{kind: (zero ? RES_ZERO : RES_EXP), err: zero, gas: in_tag.gas};
      sat_r[0] <= sat;
      rem_r[0] <= RW'(meas >> 8);
      q_r[0]   <= '0;
      lo_r[0]  <= meas[7:0];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int J = NS - 1 - k;
    logic          nb;
    logic [RW:0]   t;
    logic          ge;
    logic [RW:0]   d;

    if (J >= 16) begin : g_data
      assign nb = lo_r[k][J-16];
    end else begin : g_pad
      assign nb = 1'b0;
    end

    assign t  = {rem_r[k], nb};
    assign ge = t >= {1'b0, air};
    assign d  = t - {1'b0, air};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k+1] <= tag_r[k];
        sat_r[k+1] <= sat_r[k];
        rem_r[k+1] <= ge ? d[RW-1:0] : t[RW-1:0];
        q_r[k+1]   <= {q_r[k][RATIO_W-2:0], ge};
        lo_r[k+1]  <= lo_r[k];
      end
    end
  end

  always_comb begin
    out_v     = v_r[NS];
    out_ratio = sat_r[NS] ? '1 : q_r[NS];
    out_tag   = tag_r[NS];
    if (tag_r[NS].kind == RES_EXP && out_ratio == '0) begin
      out_tag.kind = RES_MAX;
    end
  end

endmodule

FILE: src/gsr_log2.sv
// Pipelined log2 of the ratio by repeated squaring of the mantissa
module gsr_log2 import gsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  gsr_tag_t                in_tag,
  input  logic [RATIO_W-1:0]      in_ratio,
  output logic                    out_v,
  output gsr_tag_t                out_tag,
  output logic [RATIO_W-1:0]      out_ratio,
  output logic signed [LOG_W-1:0] out_log
);

  localparam int NS = FRAC_W;

  logic               v_r     [0:NS];
  gsr_tag_t           tag_r   [0:NS];
  logic [RATIO_W-1:0] ratio_r [0:NS];
  logic [31:0]        m_r     [0:NS];
  logic [FRAC_W-1:0]  fr_r    [0:NS];
  logic [4:0]         ip_r    [0:NS];

  logic [4:0] p;
  logic [5:0] ip;

  always_comb begin
    p = '0;
    for (int i = 0; i < RATIO_W; i++) begin
      if (in_ratio[i]) begin
        p = 5'(i);
      end
    end
    ip = {1'b0, p} - 6'd16;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0]   <= in_tag;
      ratio_r[0] <= in_ratio;
      m_r[0]     <= 32'(in_ratio) << (5'd31 - p);
      fr_r[0]    <= '0;
      ip_r[0]    <= ip[4:0];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sq
    logic [63:0] sq;

    assign sq = 64'(m_r[k]) * 64'(m_r[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k+1]   <= tag_r[k];
        ratio_r[k+1] <= ratio_r[k];
        ip_r[k+1]    <= ip_r[k];
        m_r[k+1]     <= sq[63] ? sq[63:32] : sq[62:31];
        fr_r[k+1]    <= {fr_r[k][FRAC_W-2:0], sq[63]};
      end
    end
  end

  assign out_v     = v_r[NS];
  assign out_tag   = tag_r[NS];
  assign out_ratio = ratio_r[NS];
  assign out_log   = $signed({ip_r[NS], fr_r[NS]});

endmodule

FILE: src/gsr_curve.sv
// Segment pick, power law scaling and pipelined floor division by the slope
module gsr_curve import gsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  gsr_tag_t                in_tag,
  input  logic [RATIO_W-1:0]      in_ratio,
  input  logic signed [LOG_W-1:0] in_log,
  output logic                    out_v,
  output gsr_tag_t                out_tag,
  output logic [EXP_W-1:0]        out_exp,
  output logic [FRAC_W-1:0]       out_frac
);

  localparam int NS = DIVQ_W;

  // segment select
  logic                    a_v_r;
  gsr_tag_t                a_tag_r;
  logic [DIVR_W-1:0]       a_an_r;
  logic signed [11:0]      a_b_r;
  logic signed [LOG_W-1:0] a_l_r;

  // numerator
  logic                    b_v_r;
  gsr_tag_t                b_tag_r;
  logic [DIVR_W-1:0]       b_an_r;
  logic signed [NUM_W-1:0] b_num_r;

  logic hi;
  assign hi = in_ratio > THR[in_tag.gas];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag_r <= in_tag;
      a_an_r  <= hi ? A_HI_N[in_tag.gas] : A_LO_N[in_tag.gas];
      a_b_r   <= hi ? B_HI[in_tag.gas] : B_LO[in_tag.gas];
      a_l_r   <= in_log;
      b_tag_r <= a_tag_r;
      b_an_r  <= a_an_r;
      b_num_r <= NUM_W'(a_l_r) * MILLI - NUM_W'(a_b_r) * LOG2_TEN_Q24;
    end
  end

  // divider
  logic              v_r   [0:NS];
  gsr_tag_t          tag_r [0:NS];
  logic              neg_r [0:NS];
  logic [DIVR_W-1:0] dn_r  [0:NS];
  logic [DIVR_W-1:0] rem_r [0:NS];
  logic [DIVQ_W-1:0] q_r   [0:NS];
  logic [DIVQ_W-1:0] lo_r  [0:NS];

  logic [NUM_W-1:0] mag;
  assign mag = b_num_r[NUM_W-1] ? NUM_W'(-b_num_r) : NUM_W'(b_num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= b_tag_r;
      neg_r[0] <= !b_num_r[NUM_W-1] && (b_num_r != '0);
      dn_r[0]  <= b_an_r;
      rem_r[0] <= DIVR_W'(mag[ABS_W-1:DIVQ_W]);
      q_r[0]   <= '0;
      lo_r[0]  <= mag[DIVQ_W-1:0];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic [DIVR_W:0] t;
    logic [DIVR_W:0] d;
    logic            ge;

    assign t  = {rem_r[k], lo_r[k][DIVQ_W-1]};
    assign ge = t >= {1'b0, dn_r[k]};
    assign d  = t - {1'b0, dn_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k+1] <= tag_r[k];
        neg_r[k+1] <= neg_r[k];
        dn_r[k+1]  <= dn_r[k];
        rem_r[k+1] <= ge ? d[DIVR_W-1:0] : t[DIVR_W-1:0];
        q_r[k+1]   <= {q_r[k][DIVQ_W-2:0], ge};
        lo_r[k+1]  <= {lo_r[k][DIVQ_W-2:0], 1'b0};
      end
    end
  end

  // floor correction and exponent split
  logic                v_out_r;
  gsr_tag_t            tag_out_r;
  logic [EXP_W-1:0]    exp_out_r;
  logic [FRAC_W-1:0]   frac_out_r;

  logic [DIVQ_W:0]       qf;
  logic signed [Y_W-1:0] y;
  logic signed [Y_W-1:0] z;
  gsr_tag_t              tag_nxt;

  always_comb begin
    qf      = {1'b0, q_r[NS]} + (DIVQ_W+1)'(neg_r[NS] && (rem_r[NS] != '0));
    y       = neg_r[NS] ? -$signed(Y_W'(qf)) : $signed(Y_W'(qf));
    z       = y + $signed(Y_W'(8) << FRAC_W);
    tag_nxt = tag_r[NS];
    if (tag_r[NS].kind == RES_EXP) begin
      if (z < 0) begin
        tag_nxt.kind = RES_ZERO;
      end else if (z >= $signed(Y_W'(24) << FRAC_W)) begin
        tag_nxt.kind = RES_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else if (en) begin
      v_out_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_out_r  <= tag_nxt;
      exp_out_r  <= z[FRAC_W+EXP_W-1:FRAC_W];
      frac_out_r <= z[FRAC_W-1:0];
    end
  end

  assign out_v    = v_out_r;
  assign out_tag  = tag_out_r;
  assign out_exp  = exp_out_r;
  assign out_frac = frac_out_r;

endmodule

FILE: src/gsr_exp2.sv
// Pipelined 2^z by products of successive square roots of two
module gsr_exp2 import gsr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  gsr_tag_t          in_tag,
  input  logic [EXP_W-1:0]  in_exp,
  input  logic [FRAC_W-1:0] in_frac,
  output logic              out_v,
  output gsr_out_t          out_res
);

  localparam int NS = FRAC_W;

  logic              v_r    [1:NS];
  gsr_tag_t          tag_r  [1:NS];
  logic [EXP_W-1:0]  exp_r  [1:NS];
  logic [FRAC_W-1:0] frac_r [1:NS];
  logic [ACC_W-1:0]  acc_r  [1:NS];

  logic              v_s    [0:NS];
  gsr_tag_t          tag_s  [0:NS];
  logic [EXP_W-1:0]  exp_s  [0:NS];
  logic [FRAC_W-1:0] frac_s [0:NS];
  logic [ACC_W-1:0]  acc_s  [0:NS];

  assign v_s[0]    = in_v;
  assign tag_s[0]  = in_tag;
  assign exp_s[0]  = in_exp;
  assign frac_s[0] = in_frac;
  assign acc_s[0]  = ACC_W'(1) << 30;

  for (genvar k = 0; k < NS; k++) begin : g_mul
    localparam logic [ACC_W-1:0] RT = gsr_root(k + 1);
    logic [63:0] prod;

    assign prod = 64'(acc_s[k]) * 64'(RT);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k+1]  <= tag_s[k];
        exp_r[k+1]  <= exp_s[k];
        frac_r[k+1] <= frac_s[k];
        acc_r[k+1]  <= frac_s[k][FRAC_W-1-k] ? prod[ACC_W+29:30] : acc_s[k];
      end
    end

    assign v_s[k+1]    = v_r[k+1];
    assign tag_s[k+1]  = tag_r[k+1];
    assign exp_s[k+1]  = exp_r[k+1];
    assign frac_s[k+1] = frac_r[k+1];
    assign acc_s[k+1]  = acc_r[k+1];
  end

  logic     out_v_r;
  gsr_out_t out_res_r;

  logic [ACC_W+22:0] w;
  logic [CONC_W:0]   code;
  gsr_out_t          res_nxt;

  always_comb begin
    w    = (ACC_W+23)'(acc_s[NS]) << exp_s[NS];
    code = w[ACC_W+22:30];
    res_nxt.error = tag_s[NS].err;
    case (tag_s[NS].kind)
      RES_ZERO: res_nxt.concentration = '0;
      RES_MAX:  res_nxt.concentration = CONC_MAX;
      RES_EXP:  res_nxt.concentration = (code > {1'b0, CONC_MAX}) ? CONC_MAX
                                                                  : code[CONC_W-1:0];
      default:  res_nxt.concentration = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_s[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_v   = out_v_r;
  assign out_res = out_res_r;

endmodule

FILE: src/gas_sensor_ratio_to_ppm_top.sv
// Top level of the gas sensor resistance ratio to ppm converter
//
// Input channel (in_valid/in_ready/in_data): one request per sample, a gas
// selector and a measured resistance in ohms. Result channel
// (out_valid/out_ready/out_data): one request per sample, ppm as unsigned
// Q16.8 plus an error flag for a zero resistance. Configuration channel
// (cfg_valid/cfg_ready/cfg_data): clean-air resistance, always ready; write
// it only while no sample is in flight.
// Samples pass ratio division, log2 squaring, segment scaling and slope
// division, then exp2 products. One sample enters per cycle unless the
// receiver stalls; each log2 and exp2 stage holds one 32x32 multiply and
// each division stage one compare and subtract.
// Reset clears all stage valid bits and sets the clean-air resistance to 1.
// When the receiver stalls, the whole pipeline holds and in_ready drops;
// nothing is lost or repeated.
module gas_sensor_ratio_to_ppm_top import gsr_pkg::*; #(
  parameter int RESISTANCE_BITS = RES_BITS_DFLT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gsr_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gsr_out_t          out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MEAS_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int RW = (RESISTANCE_BITS < MEAS_W) ? RESISTANCE_BITS : MEAS_W;

  logic [MEAS_W-1:0] air_r;
  logic              en;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      air_r <= AIR_RESET;
    end else if (cfg_valid) begin
      air_r <= cfg_data;
    end
  end

  gsr_tag_t           in_tag;
  logic               div_v;
  gsr_tag_t           div_tag;
  logic [RATIO_W-1:0] div_ratio;

  assign in_tag = '{kind: RES_EXP, err: 1'b0, gas: in_data.gas_kind};

  gsr_ratio_div #(.RW(RW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (in_valid && in_ready),
    .in_tag    (in_tag),
    .meas      (in_data.measured_resistance[RW-1:0]),
    .air       (air_r[RW-1:0]),
    .out_v     (div_v),
    .out_tag   (div_tag),
    .out_ratio (div_ratio)
  );

  logic                    log_v;
  gsr_tag_t                log_tag;
  logic [RATIO_W-1:0]      log_ratio;
  logic signed [LOG_W-1:0] log_val;

  gsr_log2 u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (div_v),
    .in_tag    (div_tag),
    .in_ratio  (div_ratio),
    .out_v     (log_v),
    .out_tag   (log_tag),
    .out_ratio (log_ratio),
    .out_log   (log_val)
  );

  logic              crv_v;
  gsr_tag_t          crv_tag;
  logic [EXP_W-1:0]  crv_exp;
  logic [FRAC_W-1:0] crv_frac;

  gsr_curve u_curve (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (log_v),
    .in_tag   (log_tag),
    .in_ratio (log_ratio),
    .in_log   (log_val),
    .out_v    (crv_v),
    .out_tag  (crv_tag),
    .out_exp  (crv_exp),
    .out_frac (crv_frac)
  );

  gsr_exp2 u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (crv_v),
    .in_tag  (crv_tag),
    .in_exp  (crv_exp),
    .in_frac (crv_frac),
    .out_v   (out_valid),
    .out_res (out_data)
  );

  `GSR_ASSERT_CLK(a_err_zero, out_valid && out_data.error |-> out_data.concentration == '0, "error result with nonzero concentration")
  `GSR_ASSERT_CLK(a_stall_blocks, out_valid && !out_ready |-> !in_ready, "input taken while output stalled")
  `GSR_ASSERT_RST(a_reset_state, !rst_n |=> !out_valid && air_r == AIR_RESET, "reset state wrong")

endmodule

FILE: verif/gas_sensor_ratio_to_ppm_top_tb.sv
// Testbench of the gas sensor ratio to ppm converter: directed table, then random requests
module gas_sensor_ratio_to_ppm_top_tb import gsr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q24_UNIT     = 64'd16777216;
  localparam longint LOG2_TEN_FIX = 64'd55732705;
  localparam int     RAND_PHASES  = 6;
  localparam int     PHASE_REQS   = 225;
  localparam int     DRAIN_CYCLES = 150;

  typedef enum logic [1:0] {
    ETHANOL,
    AMMONIA,
    SULFIDE,
    THIOL
  } gas_e;

  typedef struct {
    logic [MEAS_W-1:0] air;
    gas_e              gas;
    logic [MEAS_W-1:0] meas;
    bit                typed;
    logic [CONC_W-1:0] conc;
    logic              err;
  } table_row_t;

  localparam int THRESH [4] = '{1310, 26214, 9175, 13107};
  localparam int SLOPE_HI [4] = '{-699, -509, -632, -778};
  localparam int OFFS_HI [4] = '{-301, -155, -854, -1106};
  localparam int SLOPE_LO [4] = '{-834, -1125, -1343, -1602};
  localparam int OFFS_LO [4] = '{-31, 139, -854, -1537};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  gsr_in_t           in_data;
  logic              out_valid;
  logic              out_ready;
  gsr_out_t          out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MEAS_W-1:0] cfg_data;

  logic [MEAS_W-1:0] air_copy;
  gsr_out_t          ppm_pending[$];
  int                send_idle;
  int                recv_stall;
  int                mismatches;
  int                reqs_sent;
  int                results_seen;
  int                err_results;
  int                max_results;
  int                zero_results;

  gas_sensor_ratio_to_ppm_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout at %0t", $time);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint ratio_log2(logic [23:0] r);
    int          p;
    logic [63:0] m;
    longint      frac;
    p = 23;
    while (p > 0 && !r[p]) p--;
    m = 64'(r) << (31 - p);
    frac = 0;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(p - 16) * Q24_UNIT + frac;
  endfunction

  function automatic logic [CONC_W-1:0] pow2_code(longint z);
    int          e;
    logic [23:0] frac;
    logic [63:0] acc;
    logic [63:0] root;
    e = int'(z / Q24_UNIT);
    frac = 24'(z % Q24_UNIT);
    acc = 64'd1 << 30;
    root = 64'd2 << 30;
    for (int i = 1; i <= 24; i++) begin
      root = int_sqrt(root << 30);
      if (frac[24 - i]) acc = (acc * root) >> 30;
    end
    acc = (acc << e) >> 30;
    if (acc > 64'(CONC_MAX)) acc = 64'(CONC_MAX);
    return acc[CONC_W-1:0];
  endfunction

  function automatic gsr_out_t predict_ppm(gsr_in_t d, logic [MEAS_W-1:0] air);
    gsr_out_t    r;
    logic [63:0] ratio;
    int          g;
    longint      a;
    longint      b;
    longint      num;
    longint      y;
    longint      z;
    g = d.gas_kind;
    r.error = 1'b0;
    if (d.measured_resistance == 0 || air == 0) begin
      r.concentration = '0;
      r.error = 1'b1;
      return r;
    end
    ratio = (64'(d.measured_resistance) << 16) / 64'(air);
    if (ratio > 64'hFF_FFFF) ratio = 64'hFF_FFFF;
    if (ratio == 0) begin
      r.concentration = CONC_MAX;
      return r;
    end
    if (ratio > 64'(THRESH[g])) begin
      a = SLOPE_HI[g];
      b = OFFS_HI[g];
    end else begin
      a = SLOPE_LO[g];
      b = OFFS_LO[g];
    end
    num = ratio_log2(ratio[23:0]) * 1000 - b * LOG2_TEN_FIX;
    y = (-num) / (-a);
    if (((-num) % (-a)) != 0 && (-num) < 0) y = y - 1;
    z = y + 8 * Q24_UNIT;
    if (z < 0) r.concentration = '0;
    else if (z >= 24 * Q24_UNIT) r.concentration = CONC_MAX;
    else r.concentration = pow2_code(z);
    return r;
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    gsr_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_data.error) err_results++;
      else if (out_data.concentration == CONC_MAX) max_results++;
      else if (out_data.concentration == 0) zero_results++;
      if (ppm_pending.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result conc=%h err=%b", $time,
                 out_data.concentration, out_data.error);
      end else begin
        want = ppm_pending.pop_front();
        if (out_data.concentration !== want.concentration) begin
          mismatches++;
          $display("%0t: concentration expected %h actual %h", $time,
                   want.concentration, out_data.concentration);
        end
        if (out_data.error !== want.error) begin
          mismatches++;
          $display("%0t: error expected %b actual %b", $time, want.error, out_data.error);
        end
      end
    end
  end

  task automatic send_req(gsr_in_t d, bit typed, gsr_out_t typed_res);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    ppm_pending.push_back(typed ? typed_res : predict_ppm(d, air_copy));
    reqs_sent++;
    @(negedge clk);
  endtask

  task automatic drain_and_write_air(logic [MEAS_W-1:0] v);
    in_valid <= 1'b0;
    while (ppm_pending.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    air_copy = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MEAS_W-1:0] pick_meas(logic [MEAS_W-1:0] air);
    case ($urandom_range(4))
      0: return MEAS_W'($urandom);
      1: return MEAS_W'($urandom) >> $urandom_range(23);
      2: return MEAS_W'($urandom_range(64));
      3: return air + MEAS_W'($urandom_range(64)) - MEAS_W'(32);
      default: return ($urandom_range(39) == 0) ? '0 : MEAS_W'($urandom) >> $urandom_range(12);
    endcase
  endfunction

  initial begin
    table_row_t rows[$];
    logic [MEAS_W-1:0] airs [RAND_PHASES];
    gsr_in_t  d;
    gsr_out_t t;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;
    air_copy = AIR_RESET;
    send_idle = 0;
    recv_stall = 0;
    mismatches = 0;
    reqs_sent = 0;
    results_seen = 0;
    err_results = 0;
    max_results = 0;
    zero_results = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int g = 0; g < 4; g++) begin
      rows.push_back('{24'd1, gas_e'(g), 24'd0, 1'b1, 24'd0, 1'b1});
      rows.push_back('{24'd1, gas_e'(g), 24'd1, 1'b0, 24'd0, 1'b0});
      rows.push_back('{24'd1, gas_e'(g), 24'hFFFFFF, 1'b0, 24'd0, 1'b0});
    end
    for (int g = 0; g < 4; g++) begin
      rows.push_back('{24'd65536, gas_e'(g), 24'(THRESH[g]), 1'b0, 24'd0, 1'b0});
      rows.push_back('{24'd65536, gas_e'(g), 24'(THRESH[g] + 1), 1'b0, 24'd0, 1'b0});
    end
    rows.push_back('{24'd0, ETHANOL, 24'd5, 1'b1, 24'd0, 1'b1});
    rows.push_back('{24'd0, THIOL, 24'hFFFFFF, 1'b1, 24'd0, 1'b1});
    rows.push_back('{24'hFFFFFF, AMMONIA, 24'd1, 1'b1, CONC_MAX, 1'b0});
    rows.push_back('{24'hFFFFFF, SULFIDE, 24'hFFFFFF, 1'b0, 24'd0, 1'b0});
    rows.push_back('{24'hFFFFFF, ETHANOL, 24'd0, 1'b1, 24'd0, 1'b1});

    foreach (rows[i]) begin
      if (rows[i].air != air_copy) drain_and_write_air(rows[i].air);
      d.gas_kind = rows[i].gas;
      d.measured_resistance = rows[i].meas;
      t.concentration = rows[i].conc;
      t.error = rows[i].err;
      send_req(d, rows[i].typed, t);
    end

    airs = '{24'd1000, 24'hFFFFFF, 24'd1, 24'($urandom), 24'($urandom_range(1, 300)), 24'd65536};
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_and_write_air(airs[ph]);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 61; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 61; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) begin
        d.gas_kind = 2'($urandom_range(3));
        d.measured_resistance = pick_meas(air_copy);
        send_req(d, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    send_idle = 0;
    recv_stall = 0;
    while (ppm_pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d requests over %0d air settings, %0d results checked", reqs_sent,
             RAND_PHASES + 4, results_seen);
    $display("Results: %0d error, %0d saturated, %0d zero", err_results, max_results,
             zero_results);
    if (mismatches == 0 && ppm_pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
